// ----- rtl/core/rank_order_window_filter_macros.svh -----
// Assertion macros used by the rank order window filter controller.
`ifndef RANK_ORDER_WINDOW_FILTER_MACROS_SVH
`define RANK_ORDER_WINDOW_FILTER_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ROWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ROWF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rowf_pkg.sv -----
// Shared types and constants of the rank order window filter.
`timescale 1ns / 1ps
package rowf_pkg;

  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int ROW_W          = 13;
  localparam int PIX_W          = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_RANK_OFFSET  = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_SETTLE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take_in;
    logic start;
    logic step;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic avail;
    logic last_read;
  } dp_stat_t;

endpackage

// ----- rtl/core/rowf_ctrl.sv -----
// Controller state machine: sequences accept, window gather and output.
`timescale 1ns / 1ps
`include "rank_order_window_filter_macros.svh"
module rowf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  rowf_pkg::dp_stat_t stat,
  output rowf_pkg::dp_cmd_t  cmd
);
  import rowf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.avail) begin
          cmd.start = 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.step = 1'b1;
        if (stat.last_read) state_nxt = ST_SETTLE;
      end
      // wait for the last read word to land in the sorter
      ST_SETTLE: state_nxt = ST_OUT;
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ROWF_ASSERT(a_one_side, !(out_tvalid && in_tready), "input taken while result pending")
  `ROWF_ASSERT(a_take_check, (in_tvalid && in_tready) |=> (state_r == ST_CHECK), "accept not checked")
  `ROWF_ASSERT(a_out_idle, (out_tvalid && out_tready) |=> in_tready, "no return to idle after output")

endmodule

// ----- rtl/core/rowf_sorter.sv -----
// Insertion sorter: keeps the gathered window pixels in ascending order.
`timescale 1ns / 1ps
module rowf_sorter #(
  parameter int NS = 49,
  parameter int IW = 6
) (
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        ins,
  input  logic [rowf_pkg::PIX_W-1:0]  din,
  input  logic [IW-1:0]               sel,
  output logic [rowf_pkg::PIX_W-1:0]  dout
);
  import rowf_pkg::*;

  logic [PIX_W-1:0] s_r   [NS];
  logic [PIX_W-1:0] s_nxt [NS];

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (din < s_r[i]) begin
        if (i > 0 && din < s_r[(i > 0) ? i - 1 : 0]) begin
          s_nxt[i] = s_r[(i > 0) ? i - 1 : 0];
        end else begin
          s_nxt[i] = din;
        end
      end else begin
        s_nxt[i] = s_r[i];
      end
    end
  end

  // fill with the top gray level so unused cells sort above the window
  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (clr) begin
        s_r[i] <= '1;
      end else if (ins) begin
        s_r[i] <= s_nxt[i];
      end
    end
  end

  assign dout = s_r[sel];

endmodule

// ----- rtl/core/rowf_datapath.sv -----
// Datapath: config registers, frame counters, line store and window gather.
`timescale 1ns / 1ps
module rowf_datapath #(
  parameter int MAX_WINDOW = rowf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = rowf_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rowf_pkg::dp_cmd_t               cmd,
  output rowf_pkg::dp_stat_t              stat,
  input  logic                            in_op,
  input  logic [rowf_pkg::PIX_W-1:0]      in_pix,
  input  logic                            cfg_we,
  input  logic [rowf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rowf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [rowf_pkg::PIX_W-1:0]      pix_out,
  output logic                            last_out
);
  import rowf_pkg::*;

  localparam int KMAX = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
  localparam int NS   = KMAX * KMAX;
  localparam int IW   = (NS > 1) ? $clog2(NS) : 1;
  localparam int CW   = $clog2(NS + 1);
  localparam int KW   = $clog2(MAX_WINDOW + 1);
  localparam int CLW  = $clog2(MAX_WIDTH + 1);
  localparam int LW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int MD   = MAX_WINDOW * MAX_WIDTH;
  localparam int AW   = $clog2(MD);

  logic [2:0]         win_size_r;
  logic signed [6:0]  rank_off_r;
  logic [10:0]        img_w_r;
  logic [12:0]        img_h_r;

  logic [CLW-1:0]   in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [SW-1:0]    in_slot_r, out_slot_r;
  logic [LW-1:0]    in_lin_r, out_lin_r;
  logic             done_r;

  logic [KW-1:0]    kk_r, gi_r, gj_r;
  logic [SW-1:0]    rs_r;
  logic [CLW-1:0]   c0_r, cc_r;
  logic [IW-1:0]    sel_r;
  logic             rd_v_r;
  logic [PIX_W-1:0] rd_data_r;
  logic [PIX_W-1:0] mem [MD];

  logic [2:0]        k3;
  logic [KW-1:0]     k_eff, n;
  logic [CW-1:0]     cnt;
  logic signed [9:0] cnt_s, sum, half;
  logic [IW-1:0]     idx;
  logic [CLW-1:0]    w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [LW-1:0]     total, lag;
  logic              border, last_pix, push;
  logic [SW-1:0]     base_slot;
  logic [AW-1:0]     wr_addr, rd_addr;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(MAX_WINDOW - 1)) ? '0 : s + SW'(1);
  endfunction

  // effective geometry from the registers
  always_comb begin
    k3 = (win_size_r == 3'd0) ? 3'd1 : (win_size_r[0] ? win_size_r : win_size_r - 3'd1);
    k_eff = (int'(k3) > KMAX) ? KW'(KMAX) : KW'(k3);
    n     = k_eff >> 1;
    cnt   = CW'(k_eff) * CW'(k_eff);
    cnt_s = $signed({1'b0, 9'(cnt)});
    sum   = cnt_s + 10'(rank_off_r);
    half  = sum >>> 1;
    if (sum <= 10'sd0) begin
      idx = '0;
    end else if (half > cnt_s - 10'sd1) begin
      idx = IW'(cnt - CW'(1));
    end else begin
      idx = IW'(half);
    end
    if (img_w_r == 11'd0) begin
      w_eff = CLW'(1);
    end else if (int'(img_w_r) > MAX_WIDTH) begin
      w_eff = CLW'(MAX_WIDTH);
    end else begin
      w_eff = CLW'(img_w_r);
    end
    if (img_h_r == 13'd0) begin
      h_eff = ROW_W'(1);
    end else if (int'(img_h_r) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(img_h_r);
    end
    total = LW'(w_eff) * LW'(h_eff);
    lag   = LW'(n) * LW'(w_eff) + LW'(n);
  end

  always_comb begin
    stat.avail = (out_lin_r < total) &&
                 (done_r || ({1'b0, out_lin_r} + {1'b0, lag} < {1'b0, in_lin_r}));
    stat.last_read = (gi_r == kk_r - KW'(1)) && (gj_r == kk_r - KW'(1));
    border = (out_row_r < ROW_W'(n)) ||
             ((ROW_W + 1)'(out_row_r) + (ROW_W + 1)'(n) >= (ROW_W + 1)'(h_eff)) ||
             (out_col_r < CLW'(n)) ||
             ((CLW + 1)'(out_col_r) + (CLW + 1)'(n) >= (CLW + 1)'(w_eff));
    base_slot = (out_slot_r >= SW'(n)) ? out_slot_r - SW'(n)
                                       : out_slot_r + SW'(MAX_WINDOW) - SW'(n);
    last_pix = (out_lin_r == total - LW'(1));
    push     = cmd.take_in && (in_op == OP_PUSH) && !done_r;
    wr_addr  = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
    rd_addr  = AW'(rs_r) * AW'(MAX_WIDTH) + AW'(cc_r);
  end

  // config registers and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= 3'd3;
      rank_off_r <= '0;
      img_w_r    <= 11'd1024;
      img_h_r    <= 13'd1024;
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      in_lin_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      out_lin_r  <= '0;
      done_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_WINDOW_SIZE:  win_size_r <= cfg_data[2:0];
        REG_RANK_OFFSET:  rank_off_r <= $signed(cfg_data[6:0]);
        REG_IMAGE_WIDTH:  img_w_r    <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: img_h_r    <= cfg_data[12:0];
        default: ;
      endcase
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      in_lin_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      out_lin_r  <= '0;
      done_r     <= 1'b0;
    end else begin
      if (push) begin
        in_lin_r <= in_lin_r + LW'(1);
        if (in_col_r + CLW'(1) >= w_eff) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + ROW_W'(1);
          in_slot_r <= slot_inc(in_slot_r);
          if (in_row_r + ROW_W'(1) >= h_eff) done_r <= 1'b1;
        end else begin
          in_col_r <= in_col_r + CLW'(1);
        end
      end
      if (cmd.advance) begin
        if (last_pix) begin
          in_col_r   <= '0;
          in_row_r   <= '0;
          in_slot_r  <= '0;
          in_lin_r   <= '0;
          out_col_r  <= '0;
          out_row_r  <= '0;
          out_slot_r <= '0;
          out_lin_r  <= '0;
          done_r     <= 1'b0;
        end else begin
          out_lin_r <= out_lin_r + LW'(1);
          if (out_col_r + CLW'(1) >= w_eff) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + ROW_W'(1);
            out_slot_r <= slot_inc(out_slot_r);
          end else begin
            out_col_r <= out_col_r + CLW'(1);
          end
        end
      end
    end
  end

  // gather walk: a border pixel is a one by one window at rank zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      kk_r   <= KW'(1);
      gi_r   <= '0;
      gj_r   <= '0;
    end else begin
      rd_v_r <= cmd.step;
      if (cmd.start) begin
        gi_r  <= '0;
        gj_r  <= '0;
        kk_r  <= border ? KW'(1) : k_eff;
        rs_r  <= border ? out_slot_r : base_slot;
        c0_r  <= border ? out_col_r : out_col_r - CLW'(n);
        cc_r  <= border ? out_col_r : out_col_r - CLW'(n);
        sel_r <= border ? '0 : idx;
      end else if (cmd.step) begin
        if (gj_r == kk_r - KW'(1)) begin
          gj_r <= '0;
          gi_r <= gi_r + KW'(1);
          cc_r <= c0_r;
          rs_r <= slot_inc(rs_r);
        end else begin
          gj_r <= gj_r + KW'(1);
          cc_r <= cc_r + CLW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_addr] <= in_pix;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) rd_data_r <= mem[rd_addr];
  end

  rowf_sorter #(
    .NS (NS),
    .IW (IW)
  ) u_sorter (
    .clk  (clk),
    .clr  (cmd.start),
    .ins  (rd_v_r),
    .din  (rd_data_r),
    .sel  (sel_r),
    .dout (pix_out)
  );

  assign last_out = last_pix;

endmodule

// ----- rtl/core/rank_order_window_filter.sv -----
// Rank order window filter top level: streaming ports, controller and datapath.
// An accepted item that releases a result goes through CHECK, READ, SETTLE and OUT (one read on the border).
// One item is handled at a time; the single line store read port feeds the sorter one window
// pixel per cycle; an item without result goes from CHECK back to IDLE.
// Reset (rst_n, synchronous): registers to defaults, counters cleared; line store not cleared.
// Config writes are taken every cycle and restart the frame.
`timescale 1ns / 1ps
module rank_order_window_filter #(
  parameter int MAX_WINDOW = rowf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = rowf_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] pixel_in
  input  logic                            in_tuser,   // [0] operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] pixel_out
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rowf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rowf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rowf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  rowf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rowf_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_op    (in_tuser),
    .in_pix   (in_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .pix_out  (out_tdata),
    .last_out (out_tlast)
  );

endmodule
